// ----- hw/rtl/lssd_pkg.sv -----
// lssd_pkg: shared constants, codes and the response descriptor table
// for the lidar scan stream decoder
// no dependencies
package lssd_pkg;

  // field widths
  localparam int OP_W      = 2;
  localparam int BYTE_W    = 8;
  localparam int STATUS_W  = 3;
  localparam int ANGLE_W   = 15;
  localparam int DIST_W    = 16;
  localparam int QUAL_W    = 6;
  localparam int OUT_DATA_W = 40;  // 38 bits of fields, padded to whole bytes
  localparam int POS_W     = 3;
  localparam int PHASE_W   = 2;

  // reset value of the bad node limit register
  localparam logic [BYTE_W-1:0] BAD_NODE_LIMIT_RST = 8'd8;

  // input event codes
  localparam logic [OP_W-1:0] OP_BYTE    = 2'd0;
  localparam logic [OP_W-1:0] OP_START   = 2'd1;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_NODE_OK  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DESC_OK  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DESC_BAD = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_LIM  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 3'd4;

  // decoder phases
  localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_DESC  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_NODES = 2'd2;

  // descriptor and node byte positions
  localparam logic [POS_W-1:0] DESC_LAST = 3'd6;
  localparam logic [POS_W-1:0] NODE_LAST = 3'd4;

  // expected scan response descriptor, one byte per position
  function automatic logic [BYTE_W-1:0] desc_byte(input logic [POS_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      3'd0:    b = 8'hA5;
      3'd1:    b = 8'h5A;
      3'd2:    b = 8'h05;
      3'd3:    b = 8'h00;
      3'd4:    b = 8'h00;
      3'd5:    b = 8'h40;
      default: b = 8'h81;
    endcase
    return b;
  endfunction

endpackage

// ----- hw/rtl/lidar_scan_stream_decoder_core.sv -----
// lidar_scan_stream_decoder_core: descriptor check and scan node decoding
// of a serial range sensor stream, one event per request
// depends on lssd_pkg
//
// Each input request carries one event: a received byte, a start scan or a
// receive timeout (tuser). The whole decode is one pass of logic between the
// decoder state and a single output register, so a result appears on the master
// side in the cycle after the request that causes it. The input side takes one
// request every clock cycle while that output register is empty or being
// drained in the same cycle. After a start the next seven bytes are
// checked against the scan descriptor, then bytes are grouped into five-byte
// nodes; a valid node reports angle (1/64 degree), distance (1/4 mm), quality
// and the new-revolution flag. Runs of invalid nodes are counted and reported
// once they reach the bad node limit, written through the configuration port
// while idle; the user must ensure this, since the block does not enforce it.
module lidar_scan_stream_decoder_core (
  input  logic                              clk,
  input  logic                              rst,
  // configuration: bad node limit
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lssd_pkg::BYTE_W-1:0]       cfg_data,
  // input events
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [lssd_pkg::BYTE_W-1:0]       s_axis_tdata,  // rx_byte
  input  logic [lssd_pkg::OP_W-1:0]         s_axis_tuser,  // op
  // results
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // angle_q6[14:0], distance_q2[30:15], quality[36:31], scan_start[37], zero pad
  output logic [lssd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic [lssd_pkg::STATUS_W-1:0]     m_axis_tuser   // status
);

  // decoder state
  logic [lssd_pkg::BYTE_W-1:0]   bad_node_limit;
  logic [lssd_pkg::PHASE_W-1:0]  phase, phase_next;
  logic [lssd_pkg::POS_W-1:0]    byte_position, byte_position_next;
  logic                          descriptor_mismatch, descriptor_mismatch_next;
  logic [lssd_pkg::BYTE_W-1:0]   bad_node_count, bad_node_count_next;
  logic [lssd_pkg::BYTE_W-1:0]   frame_bytes [4];

  // output register
  logic                              out_valid;
  logic [lssd_pkg::STATUS_W-1:0]     out_status;
  logic [lssd_pkg::OUT_DATA_W-1:0]   out_data;

  // decode results
  logic                              in_req;
  logic                              frame_we;
  logic                              res_valid;
  logic [lssd_pkg::STATUS_W-1:0]     res_status;
  logic [lssd_pkg::OUT_DATA_W-1:0]   res_data;
  logic [lssd_pkg::POS_W-1:0]        desc_pos;
  logic [lssd_pkg::BYTE_W-1:0]       count_inc;
  logic                              node_valid;
  logic [lssd_pkg::ANGLE_W-1:0]      node_angle;
  logic [lssd_pkg::DIST_W-1:0]       node_dist;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_req        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = out_data;

  // node fields from the four stored bytes and the current byte
  assign node_valid = frame_bytes[1][0] && (frame_bytes[0][0] != frame_bytes[0][1]);
  assign node_angle = {frame_bytes[2], frame_bytes[1][7:1]};
  assign node_dist  = {s_axis_tdata, frame_bytes[3]};
  assign count_inc  = bad_node_count + 8'd1;
  assign desc_pos   = (byte_position > lssd_pkg::DESC_LAST) ? lssd_pkg::DESC_LAST
                                                            : byte_position;

  // next state and result for one request
  always_comb begin
    phase_next               = phase;
    byte_position_next       = byte_position;
    descriptor_mismatch_next = descriptor_mismatch;
    bad_node_count_next      = bad_node_count;
    frame_we                 = 1'b0;
    res_valid                = 1'b0;
    res_status               = lssd_pkg::ST_NODE_OK;
    res_data                 = '0;
    case (s_axis_tuser)
      lssd_pkg::OP_START: begin
        phase_next               = lssd_pkg::PH_DESC;
        byte_position_next       = '0;
        descriptor_mismatch_next = 1'b0;
        bad_node_count_next      = '0;
      end
      lssd_pkg::OP_TIMEOUT: begin
        if (phase == lssd_pkg::PH_DESC) begin
          phase_next = lssd_pkg::PH_IDLE;
        end
        byte_position_next       = '0;
        descriptor_mismatch_next = 1'b0;
        bad_node_count_next      = '0;
        res_valid                = 1'b1;
        res_status               = lssd_pkg::ST_TIMEOUT;
      end
      lssd_pkg::OP_BYTE: begin
        case (phase)
          lssd_pkg::PH_DESC: begin
            // compare against the descriptor, report on the last byte
            if (desc_pos != lssd_pkg::DESC_LAST) begin
              if (s_axis_tdata != lssd_pkg::desc_byte(desc_pos)) begin
                descriptor_mismatch_next = 1'b1;
              end
              byte_position_next = desc_pos + 3'd1;
            end else begin
              byte_position_next       = '0;
              descriptor_mismatch_next = 1'b0;
              res_valid                = 1'b1;
              if (descriptor_mismatch
                  || (s_axis_tdata != lssd_pkg::desc_byte(desc_pos))) begin
                phase_next = lssd_pkg::PH_IDLE;
                res_status = lssd_pkg::ST_DESC_BAD;
              end else begin
                phase_next = lssd_pkg::PH_NODES;
                res_status = lssd_pkg::ST_DESC_OK;
              end
            end
          end
          lssd_pkg::PH_NODES: begin
            if (byte_position < lssd_pkg::NODE_LAST) begin
              frame_we           = 1'b1;
              byte_position_next = byte_position + 3'd1;
            end else begin
              byte_position_next = '0;
              if (node_valid) begin
                bad_node_count_next = '0;
                res_valid           = 1'b1;
                res_status          = lssd_pkg::ST_NODE_OK;
                res_data            = {2'b00, frame_bytes[0][0], frame_bytes[0][7:2],
                                       node_dist, node_angle};
              end else if (count_inc >= bad_node_limit) begin
                // run of invalid nodes reached the limit
                bad_node_count_next = '0;
                res_valid           = 1'b1;
                res_status          = lssd_pkg::ST_BAD_LIM;
              end else begin
                bad_node_count_next = count_inc;
              end
            end
          end
          default: begin
            // bytes outside a scan are dropped
          end
        endcase
      end
      default: begin
        // unused event code, no effect
      end
    endcase
  end

  // decoder control state and configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      bad_node_limit      <= lssd_pkg::BAD_NODE_LIMIT_RST;
      phase               <= lssd_pkg::PH_IDLE;
      byte_position       <= '0;
      descriptor_mismatch <= 1'b0;
      bad_node_count      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        bad_node_limit <= cfg_data;
      end
      if (in_req) begin
        phase               <= phase_next;
        byte_position       <= byte_position_next;
        descriptor_mismatch <= descriptor_mismatch_next;
        bad_node_count      <= bad_node_count_next;
      end
    end
  end

  // node byte store
  always_ff @(posedge clk) begin
    if (in_req && frame_we) begin
      frame_bytes[byte_position[1:0]] <= s_axis_tdata;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_req && res_valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_req && res_valid) begin
      out_status <= res_status;
      out_data   <= res_data;
    end
  end

endmodule
